>>> design/circular_flash_log_append_planner_macros.svh
// ----------------------------------------------------------------------------
// circular flash log append planner assertion macros
// concurrent checks on the rising clock edge, off while reset is low
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_FLASH_LOG_APPEND_PLANNER_MACROS_SVH
`define CIRCULAR_FLASH_LOG_APPEND_PLANNER_MACROS_SVH

`ifndef SYNTHESIS

// antecedent now, consequent in the same cycle
`define CFLAP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cflap assertion failed");

// antecedent now, consequent in the next cycle
`define CFLAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cflap assertion failed");

`else

`define CFLAP_ASSERT_NOW(lbl, ante, cons)
`define CFLAP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> design/cflap_pkg.sv
// ----------------------------------------------------------------------------
// cflap_pkg
// geometry, field widths, codes and control types of the log append planner
// ----------------------------------------------------------------------------
package cflap_pkg;

  // log geometry
  localparam int SECTOR_BYTES = 4096;
  localparam int SECTOR_COUNT = 16;
  localparam int PAGE_BYTES   = 256;   // power of two
  localparam int MAX_PAYLOAD  = 256;
  localparam int HEADER_BYTES = 20;

  // field widths
  localparam int FUNC_W  = 1;
  localparam int LEN_W   = 16;
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 24;
  localparam int BYTES_W = 13;
  localparam int ROFF_W  = 12;
  localparam int ID_W    = 32;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 32;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // internal widths
  localparam int SEC_W  = $clog2(SECTOR_COUNT);
  localparam int WO_W   = $clog2(SECTOR_BYTES + 1);
  localparam int PGO_W  = $clog2(PAGE_BYTES);
  localparam int PGL_W  = $clog2(PAGE_BYTES + 1);
  localparam int LTOT_W = LEN_W + 1;
  localparam int SUM_W  = LTOT_W + 1;

  typedef enum logic [KIND_W-1:0] {
    K_PAD    = 2'd0,
    K_ERASE  = 2'd1,
    K_CHUNK  = 2'd2,
    K_STATUS = 2'd3
  } cflap_kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_FULL    = 2'd2
  } cflap_status_e;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_STOP_WHEN_FULL = 1'b0,
    REG_AREA_BASE      = 1'b1
  } cflap_reg_e;

  typedef enum logic [2:0] {
    OP_PAD   = 3'd0,
    OP_ERASE = 3'd1,
    OP_FMT   = 3'd2,
    OP_CHUNK = 3'd3,
    OP_BAD   = 3'd4,
    OP_FULL  = 3'd5
  } cflap_op_e;

  typedef struct packed {
    logic      load_in;
    logic      prep;
    logic      fmt_init;
    logic      advance;
    logic      emit;
    cflap_op_e op;
  } cflap_cmd_t;

  typedef struct packed {
    logic func;
    logic bad_len;
    logic need_move;
    logic pad_fits;
    logic full;
    logic chunk_last;
    logic fmt_last;
  } cflap_stat_t;

  typedef struct packed {
    logic [KIND_W-1:0]  command_kind;
    logic [ADDR_W-1:0]  flash_address;
    logic [BYTES_W-1:0] byte_count;
    logic [ROFF_W-1:0]  record_offset;
    logic [ID_W-1:0]    record_id;
    logic [STAT_W-1:0]  status;
    logic [CNT_W-1:0]   erases_so_far;
    logic               last;
  } cflap_res_t;

endpackage

>>> design/cflap_ifs.sv
// ----------------------------------------------------------------------------
// cflap channel interfaces
// valid/ready channels for input items and planned flash commands
// ----------------------------------------------------------------------------
interface cflap_in_if;
  import cflap_pkg::*;

  logic             valid;
  logic             ready;
  logic [FUNC_W-1:0] func;
  logic [LEN_W-1:0]  payload_length;

  modport source (output valid, output func, output payload_length, input ready);
  modport sink   (input valid, input func, input payload_length, output ready);
endinterface

interface cflap_out_if;
  import cflap_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  command_kind;
  logic [ADDR_W-1:0]  flash_address;
  logic [BYTES_W-1:0] byte_count;
  logic [ROFF_W-1:0]  record_offset;
  logic [ID_W-1:0]    record_id;
  logic [STAT_W-1:0]  status;
  logic [CNT_W-1:0]   erases_so_far;
  logic               last;

  modport source (
    output valid, output command_kind, output flash_address, output byte_count,
    output record_offset, output record_id, output status, output erases_so_far,
    output last, input ready
  );
  modport sink (
    input valid, input command_kind, input flash_address, input byte_count,
    input record_offset, input record_id, input status, input erases_so_far,
    input last, output ready
  );
endinterface

>>> design/cflap_ctrl.sv
// ----------------------------------------------------------------------------
// cflap_ctrl
// sequencer that walks one item through check, pad, move, erase, setup, chunk, format and error steps
// ----------------------------------------------------------------------------
module cflap_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  input  logic                  stop_when_full_i,
  input  cflap_pkg::cflap_stat_t stat_i,
  output cflap_pkg::cflap_cmd_t  cmd_o
);
  import cflap_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHECK = 10'b0000000010,
    S_PAD   = 10'b0000000100,
    S_MOVE  = 10'b0000001000,
    S_ERASE = 10'b0000010000,
    S_SETUP = 10'b0000100000,
    S_CHUNK = 10'b0001000000,
    S_FMT   = 10'b0010000000,
    S_BAD   = 10'b0100000000,
    S_FULL  = 10'b1000000000
  } cflap_state_e;

  cflap_state_e state_q, state_d;
  logic         out_valid_q, out_valid_d;
  logic         slot_free;

  // the output register can take a new result this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.op      = OP_PAD;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.prep = 1'b1;
        if (stat_i.func) begin
          cmd_o.fmt_init = 1'b1;
          state_d        = S_FMT;
        end else if (stat_i.bad_len) begin
          state_d = S_BAD;
        end else if (stat_i.need_move) begin
          state_d = stat_i.pad_fits ? S_PAD : S_MOVE;
        end else begin
          state_d = S_CHUNK;
        end
      end
      S_PAD: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.op   = OP_PAD;
          state_d    = S_MOVE;
        end
      end
      S_MOVE: begin
        if (stat_i.full) begin
          state_d = stop_when_full_i ? S_FULL : S_ERASE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_SETUP;
        end
      end
      S_ERASE: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.op   = OP_ERASE;
          state_d    = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_CHUNK;
      end
      S_CHUNK: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.op   = OP_CHUNK;
          if (stat_i.chunk_last) state_d = S_IDLE;
        end
      end
      S_FMT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.op   = OP_FMT;
          if (stat_i.fmt_last) state_d = S_IDLE;
        end
      end
      S_BAD: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.op   = OP_BAD;
          state_d    = S_IDLE;
        end
      end
      S_FULL: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.op   = OP_FULL;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> design/cflap_dpath.sv
// ----------------------------------------------------------------------------
// cflap_dpath
// log pointers, chunk walker and result register of the append planner
// ----------------------------------------------------------------------------
module cflap_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [cflap_pkg::FUNC_W-1:0] func_i,
  input  logic [cflap_pkg::LEN_W-1:0]  payload_length_i,
  input  logic [cflap_pkg::ADDR_W-1:0] area_base_i,
  input  cflap_pkg::cflap_cmd_t        cmd_i,
  output cflap_pkg::cflap_stat_t       stat_o,
  output cflap_pkg::cflap_res_t        res_o
);
  import cflap_pkg::*;

  // item latched at accept
  logic [FUNC_W-1:0] func_q;
  logic [LEN_W-1:0]  len_q;

  // log state
  logic [WO_W-1:0]  wo_q,  wo_d;
  logic [ID_W-1:0]  id_q,  id_d;
  logic [SEC_W-1:0] old_q, old_d;
  logic [SEC_W-1:0] act_q, act_d;
  logic [CNT_W-1:0] ers_q, ers_d;
  logic [SEC_W-1:0] sec_q, sec_d;

  // chunk walker
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [WO_W-1:0]   off_q,  off_d;
  logic [WO_W-1:0]   tot_q,  tot_d;

  cflap_res_t res_q, res_d;

  logic [LTOT_W-1:0] tot_full;
  logic [SUM_W-1:0]  end_sum;
  logic [SEC_W-1:0]  nxt_sec;
  logic [SEC_W-1:0]  old_inc;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] nxt_start;
  logic [ADDR_W-1:0] fmt_start;
  logic [WO_W-1:0]   rem;
  logic [PGL_W-1:0]  page_room;
  logic [WO_W-1:0]   chunk;
  logic              chunk_last;
  logic [CNT_W-1:0]  ers_inc;

  function automatic logic [ADDR_W-1:0] sec_start(input logic [ADDR_W-1:0] base,
                                                  input logic [SEC_W-1:0]  sec);
    logic [ADDR_W-1:0] ofs;
    ofs = ADDR_W'(sec) * ADDR_W'(SECTOR_BYTES);
    return base + ofs;
  endfunction

  assign tot_full  = LTOT_W'(len_q) + LTOT_W'(HEADER_BYTES);
  assign end_sum   = SUM_W'(wo_q) + SUM_W'(tot_full);
  assign nxt_sec   = (act_q == SEC_W'(SECTOR_COUNT - 1)) ? '0 : act_q + 1'b1;
  assign old_inc   = (old_q == SEC_W'(SECTOR_COUNT - 1)) ? '0 : old_q + 1'b1;
  assign cur_addr  = sec_start(area_base_i, act_q) + ADDR_W'(wo_q);
  assign nxt_start = sec_start(area_base_i, nxt_sec);
  assign fmt_start = sec_start(area_base_i, sec_q);
  assign ers_inc   = (ers_q == '1) ? ers_q : ers_q + 1'b1;

  // chunk never crosses a page boundary
  assign rem        = tot_q - off_q;
  assign page_room  = PGL_W'(PAGE_BYTES) - PGL_W'(addr_q[PGO_W-1:0]);
  assign chunk_last = (rem <= WO_W'(page_room));
  assign chunk      = chunk_last ? rem : WO_W'(page_room);

  assign stat_o.func       = func_q[0];
  assign stat_o.bad_len    = (len_q == '0) || (len_q > LEN_W'(MAX_PAYLOAD))
                             || (tot_full > LTOT_W'(SECTOR_BYTES));
  assign stat_o.need_move  = end_sum > SUM_W'(SECTOR_BYTES);
  assign stat_o.pad_fits   = (WO_W'(SECTOR_BYTES) - wo_q) >= WO_W'(HEADER_BYTES);
  assign stat_o.full       = (nxt_sec == old_q);
  assign stat_o.chunk_last = chunk_last;
  assign stat_o.fmt_last   = (sec_q == SEC_W'(SECTOR_COUNT - 1));

  always_comb begin
    wo_d   = wo_q;
    id_d   = id_q;
    old_d  = old_q;
    act_d  = act_q;
    ers_d  = ers_q;
    sec_d  = sec_q;
    addr_d = addr_q;
    off_d  = off_q;
    tot_d  = tot_q;
    res_d  = res_q;

    if (cmd_i.prep) begin
      addr_d = cur_addr;
      off_d  = '0;
      tot_d  = WO_W'(tot_full);
    end
    if (cmd_i.fmt_init) begin
      wo_d  = '0;
      id_d  = ID_W'(1);
      old_d = '0;
      act_d = '0;
      ers_d = '0;
      sec_d = '0;
    end
    if (cmd_i.advance) begin
      act_d = nxt_sec;
      wo_d  = '0;
    end
    if (cmd_i.emit) begin
      res_d.command_kind  = K_STATUS;
      res_d.flash_address = '0;
      res_d.byte_count    = '0;
      res_d.record_offset = '0;
      res_d.record_id     = '0;
      res_d.status        = ST_OK;
      res_d.erases_so_far = ers_q;
      res_d.last          = 1'b0;
      case (cmd_i.op)
        OP_PAD: begin
          res_d.command_kind  = K_PAD;
          res_d.flash_address = addr_q;
          res_d.byte_count    = BYTES_W'(HEADER_BYTES);
          res_d.record_id     = id_q;
        end
        OP_ERASE: begin
          res_d.command_kind  = K_ERASE;
          res_d.flash_address = nxt_start;
          res_d.record_id     = id_q;
          res_d.erases_so_far = ers_inc;
          ers_d               = ers_inc;
          old_d               = old_inc;
          act_d               = nxt_sec;
          wo_d                = '0;
        end
        OP_FMT: begin
          res_d.command_kind  = K_ERASE;
          res_d.flash_address = fmt_start;
          res_d.last          = stat_o.fmt_last;
          sec_d               = sec_q + 1'b1;
        end
        OP_CHUNK: begin
          res_d.command_kind  = K_CHUNK;
          res_d.flash_address = addr_q;
          res_d.byte_count    = BYTES_W'(chunk);
          res_d.record_offset = ROFF_W'(off_q);
          res_d.record_id     = id_q;
          res_d.last          = chunk_last;
          addr_d              = addr_q + ADDR_W'(chunk);
          off_d               = off_q + chunk;
          if (chunk_last) begin
            wo_d = wo_q + tot_q;
            id_d = id_q + 1'b1;
          end
        end
        OP_BAD: begin
          res_d.status = ST_BAD_LEN;
          res_d.last   = 1'b1;
        end
        OP_FULL: begin
          res_d.status = ST_FULL;
          res_d.last   = 1'b1;
        end
        default: begin
          res_d.last = 1'b1;
        end
      endcase
    end
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wo_q  <= '0;
      id_q  <= ID_W'(1);
      old_q <= '0;
      act_q <= '0;
      ers_q <= '0;
      sec_q <= '0;
    end else begin
      wo_q  <= wo_d;
      id_q  <= id_d;
      old_q <= old_d;
      act_q <= act_d;
      ers_q <= ers_d;
      sec_q <= sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= func_i;
      len_q  <= payload_length_i;
    end
    addr_q <= addr_d;
    off_q  <= off_d;
    tot_q  <= tot_d;
    res_q  <= res_d;
  end

endmodule

>>> design/circular_flash_log_append_planner.sv
// ----------------------------------------------------------------------------
// circular_flash_log_append_planner
// order: an accepted item passes a check step, then its results go to the
//   registered output; pad, move, sector erase and setup steps may come
//   between; a format emits one erase per sector
// a new item is taken only once the last result of the previous one is
//   emitted; each result waits in the sequencer while the sink stalls
// reset: asynchronous, clears the log pointers, erase count, sequencer and
//   config registers, not the chunk walker or result; record id restarts at one
// ----------------------------------------------------------------------------
`include "circular_flash_log_append_planner_macros.svh"

module circular_flash_log_append_planner (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cflap_in_if.sink                     in_i,
  cflap_out_if.source                  out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cflap_pkg::CFG_AW-1:0] paddr,
  input  logic [cflap_pkg::CFG_DW-1:0] pwdata,
  output logic [cflap_pkg::CFG_DW-1:0] prdata,
  output logic                         pready
);
  import cflap_pkg::*;

  logic              stop_q, stop_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic              cfg_wr;
  cflap_reg_e        reg_sel;

  cflap_cmd_t  cmd;
  cflap_stat_t stat;
  cflap_res_t  res;
  logic        out_valid;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = cflap_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    stop_d = stop_q;
    base_d = base_q;
    if (cfg_wr) begin
      case (reg_sel)
        REG_STOP_WHEN_FULL: stop_d = pwdata[0];
        REG_AREA_BASE:      base_d = pwdata[ADDR_W-1:0];
        default:            stop_d = stop_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_STOP_WHEN_FULL: prdata = CFG_DW'(stop_q);
      REG_AREA_BASE:      prdata = CFG_DW'(base_q);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q <= 1'b0;
      base_q <= '0;
    end else begin
      stop_q <= stop_d;
      base_q <= base_d;
    end
  end

  cflap_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .in_ready_o       (in_i.ready),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_valid),
    .stop_when_full_i (stop_q),
    .stat_i           (stat),
    .cmd_o            (cmd)
  );

  cflap_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .func_i           (in_i.func),
    .payload_length_i (in_i.payload_length),
    .area_base_i      (base_q),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .res_o            (res)
  );

  assign out_o.valid         = out_valid;
  assign out_o.command_kind  = res.command_kind;
  assign out_o.flash_address = res.flash_address;
  assign out_o.byte_count    = res.byte_count;
  assign out_o.record_offset = res.record_offset;
  assign out_o.record_id     = res.record_id;
  assign out_o.status        = res.status;
  assign out_o.erases_so_far = res.erases_so_far;
  assign out_o.last          = res.last;

  `CFLAP_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready)
  `CFLAP_ASSERT_NOW(a_error_is_last, out_o.valid && (out_o.status != ST_OK), out_o.last)
  `CFLAP_ASSERT_NOW(a_chunk_in_page, out_o.valid && (out_o.command_kind == K_CHUNK), (out_o.byte_count != '0) && (out_o.byte_count <= BYTES_W'(PAGE_BYTES)))
  `CFLAP_ASSERT_NOW(a_erase_no_bytes, out_o.valid && (out_o.command_kind == K_ERASE), (out_o.byte_count == '0) && (out_o.record_offset == '0))

endmodule

>>> bench/tb_circular_flash_log_append_planner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_flash_log_append_planner
// self-checking bench: appends and formats go in on the input channel, a
// scoreboard plans the same flash commands and checks every command that
// comes out, under random stalls on both channels and several register settings
// ----------------------------------------------------------------------------
module tb_circular_flash_log_append_planner;
  import cflap_pkg::*;

  localparam int MAX_CMDS   = 16;
  localparam int QUIET_MAX  = 3000;
  localparam int HOLD_LEN   = 300;
  localparam int TAIL_WAIT  = 10;

  class flash_plan_board;
    bit          stop_full = 1'b0;
    bit [23:0]   base      = '0;
    int          wr_off    = 0;
    bit [31:0]   next_id   = 32'd1;
    int          oldest    = 0;
    int          active    = 0;
    bit [31:0]   erase_cnt = '0;
    int          batch_n   = 0;
    cflap_res_t  cmd_q[$];
    int unsigned fails = 0, n_items = 0, n_cmds = 0;
    int unsigned n_erase = 0, n_pad = 0, n_full = 0, n_bad = 0;

    function void set_reg(cflap_reg_e idx, logic [31:0] val);
      if (idx == REG_STOP_WHEN_FULL) stop_full = val[0];
      else base = val[23:0];
    endfunction

    function bit [31:0] sec_base(int sec);
      return 32'(base) + 32'(sec) * 32'(SECTOR_BYTES);
    endfunction

    function void push_cmd(cflap_kind_e kind, bit [31:0] addr, int bytes, int off,
                           bit [31:0] id, cflap_status_e st);
      cflap_res_t c;
      if (batch_n >= MAX_CMDS) return;
      c.command_kind  = kind;
      c.flash_address = addr[ADDR_W-1:0];
      c.byte_count    = BYTES_W'(bytes);
      c.record_offset = ROFF_W'(off);
      c.record_id     = id;
      c.status        = st;
      c.erases_so_far = erase_cnt;
      c.last          = 1'b0;
      cmd_q.push_back(c);
      batch_n++;
      if (kind == K_PAD) n_pad++;
      if (kind == K_ERASE) n_erase++;
      if (st == ST_FULL) n_full++;
      if (st == ST_BAD_LEN) n_bad++;
    endfunction

    // plans the commands of one accepted transaction
    function void note_item(bit fn, logic [15:0] len);
      int        total, off, page_room, chunk, nxt;
      bit [31:0] id, addr;
      bit        placed;
      batch_n = 0;
      n_items++;
      if (fn) begin
        wr_off    = 0;
        oldest    = 0;
        active    = 0;
        next_id   = 32'd1;
        erase_cnt = '0;
        for (int s = 0; s < SECTOR_COUNT; s++)
          push_cmd(K_ERASE, sec_base(s), 0, 0, '0, ST_OK);
      end else begin
        total = HEADER_BYTES + int'(len);
        id    = next_id;
        if (len == 0 || len > MAX_PAYLOAD || total > SECTOR_BYTES) begin
          push_cmd(K_STATUS, '0, 0, 0, '0, ST_BAD_LEN);
        end else begin
          placed = 1'b1;
          if (wr_off + total > SECTOR_BYTES) begin
            if (SECTOR_BYTES - wr_off >= HEADER_BYTES)
              push_cmd(K_PAD, sec_base(active) + 32'(wr_off), HEADER_BYTES, 0, id, ST_OK);
            nxt = (active + 1) % SECTOR_COUNT;
            if (nxt == oldest && stop_full) begin
              push_cmd(K_STATUS, '0, 0, 0, '0, ST_FULL);
              placed = 1'b0;
            end else begin
              if (nxt == oldest) begin
                if (erase_cnt != '1) erase_cnt++;
                push_cmd(K_ERASE, sec_base(nxt), 0, 0, id, ST_OK);
                oldest = (oldest + 1) % SECTOR_COUNT;
              end
              active = nxt;
              wr_off = 0;
            end
          end
          if (placed) begin
            addr = sec_base(active) + 32'(wr_off);
            off  = 0;
            // chunks never cross a page boundary
            while (off < total) begin
              page_room = PAGE_BYTES - int'(addr % PAGE_BYTES);
              chunk     = (total - off < page_room) ? total - off : page_room;
              push_cmd(K_CHUNK, addr, chunk, off, id, ST_OK);
              addr += 32'(chunk);
              off  += chunk;
            end
            wr_off += total;
            next_id = next_id + 32'd1;
          end
        end
      end
      cmd_q[cmd_q.size()-1].last = 1'b1;
    endfunction

    function void cmp_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
        fails++;
      end
    endfunction

    function void check_result(cflap_res_t got);
      cflap_res_t exp_c;
      if (cmd_q.size() == 0) begin
        $display("%0t: unplanned command, expected none actual kind %0h addr %0h",
                 $time, got.command_kind, got.flash_address);
        fails++;
        return;
      end
      exp_c = cmd_q.pop_front();
      n_cmds++;
      cmp_field("command_kind", exp_c.command_kind, got.command_kind);
      cmp_field("flash_address", exp_c.flash_address, got.flash_address);
      cmp_field("byte_count", exp_c.byte_count, got.byte_count);
      cmp_field("record_offset", exp_c.record_offset, got.record_offset);
      cmp_field("record_id", exp_c.record_id, got.record_id);
      cmp_field("status", exp_c.status, got.status);
      cmp_field("erases_so_far", exp_c.erases_so_far, got.erases_so_far);
      cmp_field("last", exp_c.last, got.last);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel, penable, pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  cflap_in_if  in_bus ();
  cflap_out_if out_bus ();

  circular_flash_log_append_planner uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  flash_plan_board plan = new;
  bit          idle_on   = 1'b1;
  int          hold_req  = 0;
  int          stall_left = 0;
  int unsigned quiet     = 0;
  cflap_res_t  seen;

  initial begin
    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_bus.valid          = 1'b0;
    in_bus.func           = '0;
    in_bus.payload_length = '0;
    out_bus.ready         = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // command sink with random stalls and the long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req   = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      seen.command_kind  = out_bus.command_kind;
      seen.flash_address = out_bus.flash_address;
      seen.byte_count    = out_bus.byte_count;
      seen.record_offset = out_bus.record_offset;
      seen.record_id     = out_bus.record_id;
      seen.status        = out_bus.status;
      seen.erases_so_far = out_bus.erases_so_far;
      seen.last          = out_bus.last;
      plan.check_result(seen);
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_MAX) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_MAX);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic reg_write(cflap_reg_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    plan.set_reg(idx, val);
  endtask

  task automatic send_item(bit fn, logic [15:0] len);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_bus.valid          <= 1'b1;
    in_bus.func           <= fn;
    in_bus.payload_length <= len;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    plan.note_item(fn, len);
  endtask

  task automatic settle();
    while (plan.cmd_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
  endtask

  // mostly near-maximal records so the log wraps, with some noise
  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return 16'($urandom_range(236, MAX_PAYLOAD));
    if (r < 95) return 16'($urandom_range(1, MAX_PAYLOAD));
    if (r < 98) return 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
    return 16'd0;
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reg_write(REG_STOP_WHEN_FULL, 32'd0);
    reg_write(REG_AREA_BASE, 32'd0);

    // directed: format, bad lengths, extremes, then fill sector 0 exactly
    send_item(1'b1, 16'($urandom));
    send_item(1'b0, 16'd0);
    send_item(1'b0, 16'(MAX_PAYLOAD + 1));
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'd1);
    repeat (14) send_item(1'b0, 16'(MAX_PAYLOAD));
    send_item(1'b0, 16'd191);
    // write point now sits on the sector end
    send_item(1'b0, 16'd1);
    in_bus.valid <= 1'b0;
    settle();

    // circular mode with the base at the top of the address space
    reg_write(REG_AREA_BASE, 32'hFF_FFFF);
    for (int i = 0; i < 250; i++) begin
      if (i == 90) hold_req = HOLD_LEN;
      send_item(1'b0, pick_len());
    end
    in_bus.valid <= 1'b0;
    settle();

    // stop mode on a wrapped log, formats later on, no idling at the end
    reg_write(REG_STOP_WHEN_FULL, 32'd1);
    reg_write(REG_AREA_BASE, 32'($urandom_range(0, 24'hFF_FFFF)));
    for (int i = 0; i < 40; i++) begin
      if (i == 28) idle_on = 1'b0;
      if (i >= 15 && $urandom_range(0, 9) == 0) send_item(1'b1, 16'($urandom));
      else send_item(1'b0, pick_len());
    end
    in_bus.valid <= 1'b0;
    settle();

    $display("run covered %0d transactions in, %0d commands out", plan.n_items, plan.n_cmds);
    $display("  %0d erases, %0d pads, %0d full refusals, %0d bad lengths",
             plan.n_erase, plan.n_pad, plan.n_full, plan.n_bad);
    if (plan.fails == 0 && plan.cmd_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
